// File: hdl/sct_pkg.sv
// Shared types, constants and helpers for the shell command tokenizer.
// No dependencies; the tokenizer core imports this package.
package sct_pkg;

  // Default word limit per command.
  localparam int unsigned MAX_WORDS_DEF = 63;

  // Saturation value of the reported word count.
  localparam logic [5:0] WORD_COUNT_SAT = 6'd63;

  // Error codes carried on the result channel.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_SQUOTE   = 3'd1;
  localparam logic [2:0] ERR_DQUOTE   = 3'd2;
  localparam logic [2:0] ERR_ESCAPE   = 3'd3;
  localparam logic [2:0] ERR_TOO_MANY = 3'd4;

  // Characters with a special meaning to the splitter.
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_SEMICOLON = 8'h3B;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  // One result beat.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       byte_valid;
    logic       word_end;
    logic       command_end;
    logic [5:0] word_count;
    logic [2:0] error_code;
  } res_t;

  // Space, tab, newline, vertical tab, form feed and carriage return.
  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

endpackage

// File: hdl/shell_command_tokenizer_core.sv
// Shell command tokenizer: splits a byte stream into words and commands.
// Depends on sct_pkg for result type, error codes and character constants.
//
//   Channel  Direction  Ports                                   Handshake
//   in       input      in_byte                                 in_valid / in_stall
//   out      output     out_byte, out_byte_valid, out_word_end,  out_valid / out_stall
//                       out_command_end, out_word_count, out_error_code
//
// One byte is taken per clock while in_stall is low; the parser state updates in the cycle it is taken.
// A result is written into the output register as its byte is accepted,
// unless the output register still holds a stalled beat.
// A one-beat skid register lets the input keep flowing while a result is stalled;
// in_stall rises only when both output register and skid register are occupied.
// Synchronous active-low reset returns the parser to the start of a command.
module shell_command_tokenizer_core #(
  parameter int unsigned MAX_WORDS = sct_pkg::MAX_WORDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_word_end,
  output logic       out_command_end,
  output logic [5:0] out_word_count,
  output logic [2:0] out_error_code
);
  import sct_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WORDS + 1);
  localparam logic [CW-1:0] MAX_WORDS_C = CW'(MAX_WORDS);

  typedef enum logic [2:0] {
    M_NORMAL,
    M_SQUOTE,
    M_DQUOTE,
    M_ESC,
    M_ESC_DQ
  } mode_t;

  // Parser state.
  mode_t         mode_r, mode_nxt;
  logic          word_open_r, word_open_nxt;
  logic [CW-1:0] words_r, words_nxt;
  logic          cmd_start_r, cmd_start_nxt;

  // Output register and skid register.
  res_t head_r, head_nxt, skid_r;
  logic head_valid_r, head_valid_nxt, skid_valid_r, skid_valid_nxt;

  logic in_acc, pop, push;
  res_t res;
  logic res_valid;
  logic end_line, term;
  logic [8:0] cnt_ext;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign end_line = (in_byte == CH_NUL) || (in_byte == CH_NEWLINE);
  assign term     = end_line || (in_byte == CH_SEMICOLON);
  assign cnt_ext  = 9'(words_r);

  // Parse one byte against the current state.
  always_comb begin
    mode_nxt      = mode_r;
    word_open_nxt = word_open_r;
    words_nxt     = words_r;
    cmd_start_nxt = cmd_start_r;
    res           = '0;
    res_valid     = 1'b0;
    if (cmd_start_r && (term || is_blank(in_byte))) begin
      // Skip separators before the first word of a command.
    end else begin
      cmd_start_nxt = 1'b0;
      case (cmd_start_r ? M_NORMAL : mode_r)
        M_SQUOTE: begin
          if (end_line) begin
            res.error_code = ERR_SQUOTE;
            res_valid      = 1'b1;
            mode_nxt       = M_NORMAL;
            word_open_nxt  = 1'b0;
            words_nxt      = '0;
            cmd_start_nxt  = 1'b1;
          end else if (in_byte == CH_SQUOTE) begin
            mode_nxt = M_NORMAL;
          end else begin
            res.byte_val   = in_byte;
            res.byte_valid = 1'b1;
            res_valid      = 1'b1;
          end
        end
        M_DQUOTE: begin
          if (end_line) begin
            res.error_code = ERR_DQUOTE;
            res_valid      = 1'b1;
            mode_nxt       = M_NORMAL;
            word_open_nxt  = 1'b0;
            words_nxt      = '0;
            cmd_start_nxt  = 1'b1;
          end else if (in_byte == CH_DQUOTE) begin
            mode_nxt = M_NORMAL;
          end else if (in_byte == CH_BACKSLASH) begin
            mode_nxt = M_ESC_DQ;
          end else begin
            res.byte_val   = in_byte;
            res.byte_valid = 1'b1;
            res_valid      = 1'b1;
          end
        end
        M_ESC, M_ESC_DQ: begin
          if (end_line) begin
            res.error_code = ERR_ESCAPE;
            res_valid      = 1'b1;
            mode_nxt       = M_NORMAL;
            word_open_nxt  = 1'b0;
            words_nxt      = '0;
            cmd_start_nxt  = 1'b1;
          end else begin
            mode_nxt       = (mode_r == M_ESC) ? M_NORMAL : M_DQUOTE;
            res.byte_val   = in_byte;
            res.byte_valid = 1'b1;
            res_valid      = 1'b1;
          end
        end
        default: begin
          mode_nxt = M_NORMAL;
          if (term || is_blank(in_byte)) begin
            if (word_open_r && (words_r >= MAX_WORDS_C)) begin
              // Closing this word would exceed the word limit.
              res.error_code = ERR_TOO_MANY;
              res_valid      = 1'b1;
              word_open_nxt  = 1'b0;
              words_nxt      = '0;
              cmd_start_nxt  = 1'b1;
            end else if (term) begin
              res.word_end    = word_open_r;
              res.command_end = 1'b1;
              if (cnt_ext + 9'(word_open_r) > 9'(WORD_COUNT_SAT)) begin
                res.word_count = WORD_COUNT_SAT;
              end else begin
                res.word_count = 6'(cnt_ext + 9'(word_open_r));
              end
              res_valid     = 1'b1;
              word_open_nxt = 1'b0;
              words_nxt     = '0;
              cmd_start_nxt = 1'b1;
            end else if (word_open_r) begin
              res.word_end  = 1'b1;
              res_valid     = 1'b1;
              word_open_nxt = 1'b0;
              words_nxt     = words_r + CW'(1);
            end
          end else begin
            word_open_nxt = 1'b1;
            if (in_byte == CH_BACKSLASH) begin
              mode_nxt = M_ESC;
            end else if (in_byte == CH_SQUOTE) begin
              mode_nxt = M_SQUOTE;
            end else if (in_byte == CH_DQUOTE) begin
              mode_nxt = M_DQUOTE;
            end else begin
              res.byte_val   = in_byte;
              res.byte_valid = 1'b1;
              res_valid      = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // Result queue: output register backed by one skid register.
  assign pop  = head_valid_r && !out_stall;
  assign push = in_acc && res_valid;

  always_comb begin
    head_nxt       = head_r;
    head_valid_nxt = head_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (pop) begin
      if (skid_valid_r) begin
        head_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        head_nxt       = res;
        head_valid_nxt = push;
      end
    end else if (!head_valid_r) begin
      head_nxt       = res;
      head_valid_nxt = push;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_NORMAL;
      word_open_r  <= 1'b0;
      words_r      <= '0;
      cmd_start_r  <= 1'b1;
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_r      <= mode_nxt;
        word_open_r <= word_open_nxt;
        words_r     <= words_nxt;
        cmd_start_r <= cmd_start_nxt;
      end
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    if (push && head_valid_r && !pop) begin
      skid_r <= res;
    end
  end

  assign out_valid       = head_valid_r;
  assign out_byte        = head_r.byte_val;
  assign out_byte_valid  = head_r.byte_valid;
  assign out_word_end    = head_r.word_end;
  assign out_command_end = head_r.command_end;
  assign out_word_count  = head_r.word_count;
  assign out_error_code  = head_r.error_code;

  // The skid register is only filled behind an occupied output register.
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> head_valid_r)
    else $error("skid register holds a beat while the output register is empty");

  // At command start nothing of a previous command is left.
  a_clean_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_start_r |-> (!word_open_r && (words_r == '0) && (mode_r == M_NORMAL)))
    else $error("parser at command start with leftover word state");

  // The count of closed words never passes the limit.
  a_word_limit: assert property (@(posedge clk) disable iff (!rst_n)
    words_r <= MAX_WORDS_C)
    else $error("word count exceeds the limit");

  // Error beats carry no word or command content.
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_error_code != ERR_NONE)) |->
      (!out_byte_valid && !out_word_end && !out_command_end && (out_word_count == '0)))
    else $error("error beat carries word content");

endmodule
